// ===== design/qpm_pkg.sv =====
package qpm_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_ERR,
        S_MI,
        S_ACC,
        S_P,
        S_D,
        S_SUM,
        S_DUTY,
        S_FIN
    } t_state;

    // pilot commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_UP    = 3'd3;
    localparam logic [2:0] CMD_DOWN  = 3'd4;

    // drive kinds
    localparam logic [1:0] DRV_NONE = 2'd0;
    localparam logic [1:0] DRV_STOP = 2'd1;
    localparam logic [1:0] DRV_MIX  = 2'd2;

    // LED patterns
    localparam logic [3:0] LED_START = 4'd15;
    localparam logic [3:0] LED_STOP  = 4'd0;
    localparam logic [3:0] LED_UP    = 4'd9;
    localparam logic [3:0] LED_DOWN  = 4'd6;

    // register indexes
    localparam logic [2:0] REG_P_TILT = 3'd0;
    localparam logic [2:0] REG_I_TILT = 3'd1;
    localparam logic [2:0] REG_D_TILT = 3'd2;
    localparam logic [2:0] REG_P_YAW  = 3'd3;
    localparam logic [2:0] REG_I_YAW  = 3'd4;
    localparam logic [2:0] REG_D_YAW  = 3'd5;
    localparam logic [2:0] REG_ROLL   = 3'd6;
    localparam logic [2:0] REG_PITCH  = 3'd7;

    localparam logic [9:0] DUTY_MIN  = 10'd750;
    localparam logic [9:0] DUTY_MAX  = 10'd950;
    localparam logic [9:0] DUTY_STOP = 10'd600;
    localparam logic [9:0] THR_RESET = 10'd750;
    localparam logic [9:0] THR_MAX   = 10'd1000;
    localparam logic [9:0] THR_STEP  = 10'd25;

    localparam int PROD_W  = 42;
    localparam int INTEG_W = 48;
    localparam int LOOP_W  = 50;
    localparam int SUM_W   = 52;
    localparam int SCL_W   = 60;

    // signed divide by 5, truncating toward zero; magnitude by reciprocal 205/1024
    function automatic logic signed [7:0] div5(input logic signed [9:0] d);
        logic [9:0]  mag;
        logic [17:0] pr;
        logic [7:0]  q;
        mag = d[9] ? 10'(-d) : d;
        pr  = 18'(mag) * 18'd205;
        q   = pr[17:10];
        return d[9] ? 8'(-q) : q;
    endfunction

endpackage

// ===== design/quad_pid_motor_mixer.sv =====
// Attitude controller with X-frame mixer.
// Input channel: i_valid / o_stall with command, sample_valid and three angles.
// An item is taken when i_valid is high and o_stall low; o_stall stays high
// while the sequencer works on it.
// Output channel: o_valid / i_stall, one result per item, held in an output
// register until taken; the block idles again and takes the next item while a
// result still waits.
// Steps: an item that leaves the block disarmed takes a command step and the
// final step; an armed item takes the command step, three PID loops of 5 steps
// on one shared 33x9 multiplier, 2 steps per motor on the mixer adder and the
// final step. o_stall drops as o_valid rises, so the next item can be taken as
// soon as the result of the last one is in the output register.
// While an earlier result still waits under i_stall, the sequencer holds in
// its final step.
// Config port: i_cfg_valid / o_cfg_ready (always ready), index and data;
// write only while idle.
// Reset (synchronous, i_rst_n low): disarmed, throttle 7.50 %, angles,
// integrators and previous errors cleared, gains at their default values.
module quad_pid_motor_mixer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_command,
    input  logic              i_sample_valid,
    input  logic signed [8:0] i_roll_angle,
    input  logic signed [8:0] i_pitch_angle,
    input  logic signed [8:0] i_yaw_angle,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_drive_kind,
    output logic [9:0]        o_motor1_duty,
    output logic [9:0]        o_motor2_duty,
    output logic [9:0]        o_motor3_duty,
    output logic [9:0]        o_motor4_duty,
    output logic              o_led_update,
    output logic [3:0]        o_led_pattern,
    output logic              o_is_armed
);
    import qpm_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_gain [6];
    logic signed [8:0] r_roll_tgt, r_pitch_tgt;

    // controller state
    logic              r_armed;
    logic [9:0]        r_thr;
    logic signed [8:0] r_held [3];
    logic signed [INTEG_W-1:0] r_integ [3];
    logic signed [7:0] r_prev [3];

    // working registers
    logic [2:0]        r_cmd;
    logic              r_smp;
    logic signed [8:0] r_smp_ang [3];
    logic [1:0]        r_k;
    logic signed [7:0] r_err;
    logic signed [LOOP_W-1:0] r_acc;
    logic signed [LOOP_W-1:0] r_lout [3];
    logic signed [SUM_W-1:0]  r_sum;
    logic [9:0]        r_wduty [4];
    logic [1:0]        r_wkind;
    logic              r_wled_upd;
    logic [3:0]        r_wled;

    // output register
    logic       r_ovalid;
    logic [1:0] r_okind;
    logic [9:0] r_oduty [4];
    logic       r_oled_upd;
    logic [3:0] r_oled;
    logic       r_oarmed;

    logic in_acc, out_free;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // shared multiplier operands
    logic [31:0]       mul_a;
    logic signed [8:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    qpm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    logic tilt;
    assign tilt = (r_k != 2'd2);

    // loop error from held angle and setpoint
    logic signed [8:0] tgt;
    logic signed [9:0] dif;
    assign tgt = (r_k == 2'd0) ? r_roll_tgt : ((r_k == 2'd1) ? r_pitch_tgt : 9'sd0);
    assign dif = 10'(r_held[r_k]) - 10'(tgt);

    // saturating integrator update
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    assign integ_sum = (INTEG_W+1)'(r_integ[r_k]) + (INTEG_W+1)'(prod);
    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_sat = integ_sum[INTEG_W-1:0];
    end

    logic signed [LOOP_W-1:0] acc_plus;
    assign acc_plus = r_acc + LOOP_W'(prod);

    // mixer sum for motor r_k: bit 1 picks roll sign, bit 0 yaw sign
    logic signed [SUM_W-1:0] sr, sp, sy, mix_sum;
    assign sr = r_k[1] ? SUM_W'(r_lout[0]) : -SUM_W'(r_lout[0]);
    assign sp = (r_k[0] ^ r_k[1]) ? -SUM_W'(r_lout[1]) : SUM_W'(r_lout[1]);
    assign sy = r_k[0] ? SUM_W'(r_lout[2]) : -SUM_W'(r_lout[2]);
    assign mix_sum = sr + sp + sy;

    // scale by 100, floor to hundredths, add throttle, clamp
    logic signed [SCL_W-1:0]  scl, sx;
    logic signed [SCL_W-25:0] q;
    logic signed [SCL_W-23:0] dsum;
    logic [9:0] duty;
    assign sx   = SCL_W'(r_sum);
    assign scl  = (sx <<< 6) + (sx <<< 5) + (sx <<< 2);
    assign q    = scl[SCL_W-1:24];
    assign dsum = (SCL_W-22)'(q) + (SCL_W-22)'($signed({1'b0, r_thr}));
    always_comb begin
        if (dsum < (SCL_W-22)'($signed({1'b0, DUTY_MIN})))      duty = DUTY_MIN;
        else if (dsum > (SCL_W-22)'($signed({1'b0, DUTY_MAX}))) duty = DUTY_MAX;
        else                                                    duty = dsum[9:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_CMD;
            S_CMD: begin
                if ((r_cmd == CMD_START) || (r_armed && (r_cmd != CMD_STOP)))
                    n_state = S_ERR;
                else
                    n_state = S_FIN;
            end
            S_ERR:  n_state = S_MI;
            S_MI:   n_state = S_ACC;
            S_ACC:  n_state = S_P;
            S_P:    n_state = S_D;
            S_D:    n_state = (r_k == 2'd2) ? S_SUM : S_ERR;
            S_SUM:  n_state = S_DUTY;
            S_DUTY: n_state = (r_k == 2'd3) ? S_FIN : S_SUM;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operand selection
    always_comb begin
        mul_a = r_gain[tilt ? 0 : 3];
        mul_b = 9'(r_err);
        unique case (r_state)
            S_MI:    mul_a = r_gain[tilt ? 1 : 4];
            S_ACC:   mul_a = r_gain[tilt ? 0 : 3];
            S_P: begin
                mul_a = r_gain[tilt ? 2 : 5];
                mul_b = 9'(r_err) - 9'(r_prev[r_k]);
            end
            default: mul_a = r_gain[tilt ? 0 : 3];
        endcase
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_thr       <= THR_RESET;
            r_ovalid    <= 1'b0;
            r_gain[0]   <= 32'd167772;
            r_gain[1]   <= 32'd1678;
            r_gain[2]   <= 32'd3355;
            r_gain[3]   <= 32'd67108864;
            r_gain[4]   <= 32'd335544;
            r_gain[5]   <= 32'd3355443;
            r_roll_tgt  <= '0;
            r_pitch_tgt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_held[i]  <= '0;
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_P_TILT: r_gain[0] <= i_cfg_data;
                    REG_I_TILT: r_gain[1] <= i_cfg_data;
                    REG_D_TILT: r_gain[2] <= i_cfg_data;
                    REG_P_YAW:  r_gain[3] <= i_cfg_data;
                    REG_I_YAW:  r_gain[4] <= i_cfg_data;
                    REG_D_YAW:  r_gain[5] <= i_cfg_data;
                    REG_ROLL:   r_roll_tgt  <= i_cfg_data[8:0];
                    REG_PITCH:  r_pitch_tgt <= i_cfg_data[8:0];
                    default: ;
                endcase
            end

            // command and sample
            if (r_state == S_CMD) begin
                case (r_cmd)
                    CMD_START: r_armed <= 1'b1;
                    CMD_STOP:  r_armed <= 1'b0;
                    CMD_UP:    r_thr <= (r_thr > THR_MAX - THR_STEP) ? THR_MAX
                                                                    : r_thr + THR_STEP;
                    CMD_DOWN:  r_thr <= (r_thr < THR_STEP) ? 10'd0 : r_thr - THR_STEP;
                    default: ;
                endcase
                if (r_smp) begin
                    for (int i = 0; i < 3; i++) r_held[i] <= r_smp_ang[i];
                end
            end

            if (r_state == S_ACC) r_integ[r_k] <= integ_sat;
            if (r_state == S_D)   r_prev[r_k]  <= r_err;

            // output valid: set by a finished item, cleared when taken
            if ((r_state == S_FIN) && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall)      r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd        <= i_command;
            r_smp        <= i_sample_valid;
            r_smp_ang[0] <= i_roll_angle;
            r_smp_ang[1] <= i_pitch_angle;
            r_smp_ang[2] <= i_yaw_angle;
        end
        case (r_state)
            S_CMD: begin
                r_k        <= 2'd0;
                r_wkind    <= (r_cmd == CMD_STOP) ? DRV_STOP : DRV_NONE;
                case (r_cmd)
                    CMD_START: begin
                        r_wled     <= LED_START;
                        r_wled_upd <= 1'b1;
                    end
                    CMD_STOP: begin
                        r_wled     <= LED_STOP;
                        r_wled_upd <= 1'b1;
                    end
                    CMD_UP: begin
                        r_wled     <= LED_UP;
                        r_wled_upd <= 1'b1;
                    end
                    CMD_DOWN: begin
                        r_wled     <= LED_DOWN;
                        r_wled_upd <= 1'b1;
                    end
                    default: begin
                        r_wled     <= LED_STOP;
                        r_wled_upd <= 1'b0;
                    end
                endcase
                for (int i = 0; i < 4; i++)
                    r_wduty[i] <= (r_cmd == CMD_STOP) ? DUTY_STOP : 10'd0;
            end
            S_ERR:  r_err <= div5(dif);
            S_ACC:  r_acc <= LOOP_W'(integ_sat);
            S_P:    r_acc <= acc_plus;
            S_D: begin
                r_lout[r_k] <= acc_plus;
                r_k         <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            S_SUM:  r_sum <= mix_sum;
            S_DUTY: begin
                r_wduty[r_k] <= duty;
                r_wkind      <= DRV_MIX;
                r_k          <= r_k + 2'd1;
            end
            S_FIN: begin
                if (out_free) begin
                    r_okind    <= r_wkind;
                    r_oled_upd <= r_wled_upd;
                    r_oled     <= r_wled;
                    r_oarmed   <= r_armed;
                    for (int i = 0; i < 4; i++) r_oduty[i] <= r_wduty[i];
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_drive_kind  = r_okind;
    assign o_motor1_duty = r_oduty[0];
    assign o_motor2_duty = r_oduty[1];
    assign o_motor3_duty = r_oduty[2];
    assign o_motor4_duty = r_oduty[3];
    assign o_led_update  = r_oled_upd;
    assign o_led_pattern = r_oled;
    assign o_is_armed    = r_oarmed;

    // checks
    a_mix_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_kind == DRV_MIX) |-> o_is_armed)
        else $error("mixed duties while disarmed");

    a_stop_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_kind == DRV_STOP) |->
            (!o_is_armed && o_motor1_duty == DUTY_STOP && o_motor4_duty == DUTY_STOP))
        else $error("stop result malformed");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !out_free) |=> (r_state == S_FIN))
        else $error("result dropped under stall");

    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_kind == DRV_MIX) |->
            (o_motor2_duty >= DUTY_MIN && o_motor2_duty <= DUTY_MAX))
        else $error("mixed duty out of range");
endmodule

// ===== design/qpm_mul.sv =====
module qpm_mul (
    input  logic                                  i_clk,
    input  logic [31:0]                           i_a,
    input  logic signed [8:0]                     i_b,
    output logic signed [qpm_pkg::PROD_W-1:0]     o_prod
);
    import qpm_pkg::*;

    // shared gain multiplier, registered product
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_a}) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule
